// ===== src/apd_pkg.sv =====
// Shared types and constants for the ASCII PNM pixel decoder.
package apd_pkg;
   localparam int DimBitsDefault = 16;
   localparam int TokenBits = 16;
   localparam int QueueDepth = 4;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_PIXEL  = 2'd1,
      KIND_ERROR  = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   localparam logic ERR_FORMAT = 1'b0;
   localparam logic ERR_EARLY_END = 1'b1;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_stream;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic [1:0]  channel_count;
      logic [7:0]  pixel_byte;
      logic        error_code;
      logic        last_pixel;
   } rsp_type;

   // Work handed from the parser to the scaling back end.
   typedef struct packed {
      rsp_type     rsp;
      logic        do_scale;
      logic [15:0] sample;
      logic [15:0] max_level;
   } job_type;
endpackage

// ===== src/apd_stream_if.sv =====
// Valid/ready channel interface used for the request and response sides.
interface apd_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== src/ascii_pnm_pixel_decoder_top.sv =====
// Top level of the ASCII PGM/PPM pixel decoder.
// Usage:
//  - req carries one file byte per transaction plus an end_of_stream flag.
//  - rsp carries header, pixel and error results.
//  - The parser takes one byte per cycle while the job queue has room.
//  - A pixel whose maxval is neither 0 nor 255 goes through the bit-serial
//    divider; other results go from the queue straight to the output register.
//  - Pixel throughput is therefore set by the shared divider, which takes
//    no new job until its result has left; bytes that give no result pass
//    at one per cycle until the four-entry queue fills.
//  - When the receiver stalls, the result stays in the output register and
//    the queue fills, after which req_ready drops.
//  - Reset clears the parser state, empties the queue and idles the divider.
//  - The final byte of a file returns the parser to its reset state.
module ascii_pnm_pixel_decoder_top #(
   parameter int DIM_BITS = apd_pkg::DimBitsDefault
) (
   input logic clock,
   input logic reset,
   apd_stream_if.sink   req,
   apd_stream_if.source rsp
);
   logic             step, job_valid, q_ne, q_room, q_ready;
   apd_pkg::job_type job, q_job;
   apd_pkg::req_type req_data;

   assign req_data = req.payload;
   assign req.ready = q_room;
   assign step = req.valid && q_room;

   apd_parser #(.DIM_BITS(DIM_BITS)) u_parser (
      .clock, .reset, .step, .req(req_data), .job_valid, .job
   );

   apd_queue u_queue (
      .clock, .reset, .push(job_valid), .push_data(job),
      .pop(q_ne && q_ready), .not_empty(q_ne), .has_room(q_room), .pop_data(q_job)
   );

   apd_scaler u_scaler (
      .clock, .reset, .job_valid(q_ne), .job(q_job), .job_ready(q_ready),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.payload)
   );

`ifndef ASSERT_OFF
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      job_valid |-> q_room) else $error("job pushed without room");
   a_kind_valid: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.payload.result_kind != apd_pkg::KIND_NONE)
      else $error("empty result kind");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.payload))
      else $error("stalled result changed");
`endif
endmodule

// ===== src/apd_parser.sv =====
// Front end: tokenizes header and pixel bytes and issues scaling jobs.
module apd_parser #(
   parameter int DIM_BITS = apd_pkg::DimBitsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  apd_pkg::req_type  req,
   output logic              job_valid,
   output apd_pkg::job_type  job
);
   typedef enum logic [6:0] {
      PH_SEEK   = 7'b0000001,
      PH_FORMAT = 7'b0000010,
      PH_WIDTH  = 7'b0000100,
      PH_HEIGHT = 7'b0001000,
      PH_MAXVAL = 7'b0010000,
      PH_PIXELS = 7'b0100000,
      PH_DONE   = 7'b1000000
   } phase_type;

   localparam logic [16:0] DimMax = 17'((32'd1 << DIM_BITS) - 1);

   phase_type   phase_ff, phase_in;
   logic        comment_ff, comment_in;
   logic [1:0]  chan_ff, chan_in;
   logic [DIM_BITS-1:0] width_ff, width_in, height_ff, height_in;
   logic [15:0] maxl_ff, maxl_in;
   logic [15:0] acc_ff, acc_in;
   logic        hasd_ff, hasd_in;
   logic [33:0] left_ff, left_in;
   // Product of width and height, kept across header tokens.
   logic [31:0] area_ff, area_in;

   logic [7:0]  b;
   logic        is_digit, tok_phase, finish;
   logic [19:0] acc_x10;
   logic [15:0] tok;
   logic [33:0] total;
   apd_pkg::kind_type kind;
   logic        err, last, scale;

   always_comb begin
      b = req.in_byte;
      is_digit = (b >= 8'h30) && (b <= 8'h39);
      tok_phase = (phase_ff == PH_WIDTH) || (phase_ff == PH_HEIGHT) ||
                  (phase_ff == PH_MAXVAL) || (phase_ff == PH_PIXELS);
      acc_x10 = {acc_ff, 3'b000} + {2'b00, acc_ff, 1'b0} + {16'd0, b[3:0] - 4'd0};
      phase_in = phase_ff;
      comment_in = comment_ff;
      chan_in = chan_ff;
      width_in = width_ff;
      height_in = height_ff;
      maxl_in = maxl_ff;
      acc_in = acc_ff;
      hasd_in = hasd_ff;
      left_in = left_ff;
      area_in = area_ff;
      kind = apd_pkg::KIND_NONE;
      err = apd_pkg::ERR_FORMAT;
      last = 1'b0;
      scale = 1'b0;
      finish = 1'b0;
      tok = acc_ff;
      // The channel count is 0, 1 or 3, so the sample total is a masked shift-add.
      total = ({2'b00, area_ff} & {34{chan_ff[0]}}) +
              ({1'b0, area_ff, 1'b0} & {34{chan_ff[1]}});
      if (phase_ff == PH_SEEK) begin
         if (comment_ff) begin
            if (b == 8'h0A) comment_in = 1'b0;
         end else if (b == 8'h23) begin
            comment_in = 1'b1;
         end else if (b == 8'h50 || b == 8'h70) begin
            phase_in = PH_FORMAT;
         end
      end else if (phase_ff == PH_FORMAT) begin
         if (b == 8'h32) begin
            chan_in = 2'd1;
            phase_in = PH_WIDTH;
         end else if (b == 8'h33) begin
            chan_in = 2'd3;
            phase_in = PH_WIDTH;
         end else begin
            kind = apd_pkg::KIND_ERROR;
            phase_in = PH_DONE;
         end
      end else if (tok_phase) begin
         if (comment_ff) begin
            if (b == 8'h0A) comment_in = 1'b0;
         end else if (is_digit) begin
            acc_in = (acc_x10 > 20'd65535) ? 16'hFFFF : acc_x10[15:0];
            hasd_in = 1'b1;
         end else begin
            finish = hasd_ff;
            if (b == 8'h23) comment_in = 1'b1;
         end
      end
      if (req.end_of_stream && tok_phase && (is_digit && !comment_ff ? 1'b1 : hasd_ff))
         finish = 1'b1;
      if (finish) begin
         tok = acc_in;
         acc_in = '0;
         hasd_in = 1'b0;
         unique case (phase_ff)
            PH_WIDTH: begin
               width_in = DIM_BITS'((17'(tok) > DimMax) ? DimMax : 17'(tok));
               phase_in = PH_HEIGHT;
            end
            PH_HEIGHT: begin
               height_in = DIM_BITS'((17'(tok) > DimMax) ? DimMax : 17'(tok));
               area_in = 32'(width_ff) * 32'(DIM_BITS'((17'(tok) > DimMax) ? DimMax
                                                                           : 17'(tok)));
               phase_in = PH_MAXVAL;
            end
            PH_MAXVAL: begin
               maxl_in = tok;
               left_in = total;
               phase_in = (total == '0) ? PH_DONE : PH_PIXELS;
               kind = apd_pkg::KIND_HEADER;
            end
            PH_PIXELS: begin
               kind = apd_pkg::KIND_PIXEL;
               scale = 1'b1;
               if (left_ff != '0) left_in = left_ff - 34'd1;
               if (left_ff <= 34'd1) begin
                  last = 1'b1;
                  phase_in = PH_DONE;
               end
            end
            default: ;
         endcase
      end
      if (req.end_of_stream && phase_in != PH_DONE) begin
         kind = apd_pkg::KIND_ERROR;
         err = apd_pkg::ERR_EARLY_END;
         last = 1'b0;
         scale = 1'b0;
      end
      job_valid = step && (kind != apd_pkg::KIND_NONE);
      job.rsp.result_kind = kind;
      job.rsp.image_width = 16'(width_in);
      job.rsp.image_height = 16'(height_in);
      job.rsp.channel_count = chan_in;
      job.rsp.pixel_byte = '0;
      job.rsp.error_code = err;
      job.rsp.last_pixel = last;
      job.do_scale = scale;
      job.sample = tok;
      job.max_level = maxl_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && req.end_of_stream)) begin
         phase_ff <= PH_SEEK;
         comment_ff <= 1'b0;
         chan_ff <= '0;
         width_ff <= '0;
         height_ff <= '0;
         maxl_ff <= '0;
         acc_ff <= '0;
         hasd_ff <= 1'b0;
         left_ff <= '0;
         area_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         comment_ff <= comment_in;
         chan_ff <= chan_in;
         width_ff <= width_in;
         height_ff <= height_in;
         maxl_ff <= maxl_in;
         acc_ff <= acc_in;
         hasd_ff <= hasd_in;
         left_ff <= left_in;
         area_ff <= area_in;
      end
   end
endmodule

// ===== src/apd_queue.sv =====
// Short job FIFO between the parser and the scaler.
module apd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  apd_pkg::job_type push_data,
   input  logic             pop,
   output logic             not_empty,
   output logic             has_room,
   output apd_pkg::job_type pop_data
);
   localparam int AW = $clog2(apd_pkg::QueueDepth);
   apd_pkg::job_type mem_ff [apd_pkg::QueueDepth];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   cnt_ff, cnt_in;

   always_comb begin
      not_empty = cnt_ff != '0;
      has_room = cnt_ff < (AW+1)'(apd_pkg::QueueDepth);
      pop_data = mem_ff[rd_ff];
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

// ===== src/apd_scaler.sv =====
// Back end: bit-serial divide of sample*255 by maxval (skipped when maxval is 0 or 255), then result register.
module apd_scaler (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  apd_pkg::job_type job,
   output logic             job_ready,
   output logic             out_valid,
   input  logic             out_ready,
   output apd_pkg::rsp_type out_data
);
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_OUT  = 3'b100
   } st_type;

   st_type      st_ff, st_in;
   apd_pkg::rsp_type rsp_ff, rsp_in;
   logic [23:0] num_ff, num_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] den_ff, den_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [16:0] trial;
   logic [23:0] prod;

   always_comb begin
      st_in = st_ff;
      rsp_in = rsp_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      prod = {job.sample, 8'd0} - {8'd0, job.sample};
      trial = {rem_ff[15:0], num_ff[23]};
      job_ready = (st_ff == ST_IDLE);
      out_valid = (st_ff == ST_OUT);
      out_data = rsp_ff;
      unique case (st_ff)
         ST_IDLE: if (job_valid) begin
            rsp_in = job.rsp;
            if (job.do_scale && job.max_level == 16'd255) begin
               rsp_in.pixel_byte = job.sample[7:0];
               st_in = ST_OUT;
            end else if (job.do_scale && job.max_level != '0) begin
               num_in = prod;
               rem_in = '0;
               den_in = job.max_level;
               cnt_in = 5'd24;
               st_in = ST_DIV;
            end else begin
               st_in = ST_OUT;
            end
         end
         ST_DIV: begin
            // Restoring division, one quotient bit per cycle into num.
            if (trial >= {1'b0, den_ff}) begin
               rem_in = trial - {1'b0, den_ff};
               num_in = {num_ff[22:0], 1'b1};
            end else begin
               rem_in = trial;
               num_in = {num_ff[22:0], 1'b0};
            end
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               rsp_in.pixel_byte = (num_in[23:8] != '0) ? 8'hFF : num_in[7:0];
               st_in = ST_OUT;
            end
         end
         ST_OUT: if (out_ready) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) st_ff <= ST_IDLE;
      else st_ff <= st_in;
   end
endmodule
